// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define FSDM_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fsdm assertion failed");

// condition in one cycle implies a condition in the next
`define FSDM_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("fsdm assertion failed");

`endif

// ===== hw/rtl/fsdm_pkg.sv =====
// shared types, constants and helpers of the binary32 sub/div/min/max unit
package fsdm_pkg;

  typedef enum logic [2:0] {
    OP_SUB  = 3'd0,
    OP_DIV  = 3'd1,
    OP_MAX  = 3'd2,
    OP_MIN  = 3'd3,
    OP_PASS = 3'd4
  } op_e;

  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] MINMAX_NAN  = 32'h7FC0_0000;

  localparam int unsigned DIV_STEPS = 28;
  localparam int unsigned ADD_LAT   = 3;
  localparam int unsigned DIV_LAT   = DIV_STEPS + 2;
  localparam int unsigned ALIGN_LAT = DIV_LAT - ADD_LAT;

  // item bookkeeping that travels unchanged down the pipe
  typedef struct packed {
    logic        last;
    logic        is_div;
    logic        spec;
    logic [31:0] spec_val;
  } hdr_t;

  // operands after classification, larger magnitude in x for subtraction
  typedef struct packed {
    hdr_t        hdr;
    logic        sign;
    logic        eff_sub;
    logic [7:0]  ex;
    logic [23:0] mx;
    logic [7:0]  ey;
    logic [23:0] my;
  } front_t;

  // unrounded result: value = m / 2^27 * 2^(e - 127), leading one at bit 27
  typedef struct packed {
    hdr_t        hdr;
    logic        sign;
    logic        zero;
    logic [10:0] e;
    logic [27:0] m;
    logic        sticky;
  } rnd_t;

  function automatic logic [4:0] lzc28(input logic [27:0] v);
    logic [4:0] n;
    n = 5'd28;
    for (int i = 0; i < 28; i++) begin
      if (v[i]) n = 5'(27 - i);
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/fsdm_front.sv =====
// operand classification, special results, min/max/pass and operand ordering
module fsdm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [31:0]     a_i,
  input  logic [31:0]     b_i,
  input  logic            last_i,
  input  logic [2:0]      op_i,
  output logic            valid_o,
  output fsdm_pkg::front_t item_o
);
  import fsdm_pkg::*;

  logic   valid_q;
  front_t item_d, item_q;

  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, both_zero;
  logic mag_a_ge, a_gt_b, b_gt_a;
  logic [7:0]  exa, exb;
  logic [23:0] ma, mb;

  always_comb begin
    a_nan  = (&a_i[30:23]) & (|a_i[22:0]);
    b_nan  = (&b_i[30:23]) & (|b_i[22:0]);
    a_inf  = (&a_i[30:23]) & ~(|a_i[22:0]);
    b_inf  = (&b_i[30:23]) & ~(|b_i[22:0]);
    a_zero = ~(|a_i[30:0]);
    b_zero = ~(|b_i[30:0]);
    both_zero = a_zero & b_zero;
    mag_a_ge  = a_i[30:0] >= b_i[30:0];
    exa = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    exb = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    ma  = {(a_i[30:23] != 8'd0), a_i[22:0]};
    mb  = {(b_i[30:23] != 8'd0), b_i[22:0]};

    if (both_zero) begin
      a_gt_b = 1'b0;
      b_gt_a = 1'b0;
    end else if (a_i[31] != b_i[31]) begin
      a_gt_b = b_i[31];
      b_gt_a = a_i[31];
    end else if (!a_i[31]) begin
      a_gt_b = a_i[30:0] > b_i[30:0];
      b_gt_a = b_i[30:0] > a_i[30:0];
    end else begin
      a_gt_b = a_i[30:0] < b_i[30:0];
      b_gt_a = b_i[30:0] < a_i[30:0];
    end

    item_d          = '0;
    item_d.hdr.last = last_i;
    item_d.ex       = exa;
    item_d.mx       = ma;
    item_d.ey       = exb;
    item_d.my       = mb;

    case (op_i)
      OP_SUB: begin
        item_d.hdr.spec = 1'b1;
        if (a_nan) begin
          item_d.hdr.spec_val = a_i | QUIET_BIT;
        end else if (b_nan) begin
          item_d.hdr.spec_val = b_i | QUIET_BIT;
        end else if (a_inf && b_inf) begin
          item_d.hdr.spec_val = (a_i[31] == b_i[31]) ? DEFAULT_NAN : a_i;
        end else if (a_inf) begin
          item_d.hdr.spec_val = a_i;
        end else if (b_inf) begin
          item_d.hdr.spec_val = {~b_i[31], b_i[30:0]};
        end else begin
          item_d.hdr.spec = 1'b0;
        end
        // a - b: b's sign flips, so equal signs mean magnitudes subtract
        item_d.eff_sub = (a_i[31] == b_i[31]);
        if (mag_a_ge) begin
          item_d.sign = a_i[31];
        end else begin
          item_d.sign = ~b_i[31];
          item_d.ex   = exb;
          item_d.mx   = mb;
          item_d.ey   = exa;
          item_d.my   = ma;
        end
      end
      OP_DIV: begin
        item_d.hdr.is_div = 1'b1;
        item_d.hdr.spec   = 1'b1;
        item_d.sign       = a_i[31] ^ b_i[31];
        if (a_nan) begin
          item_d.hdr.spec_val = a_i | QUIET_BIT;
        end else if (b_nan) begin
          item_d.hdr.spec_val = b_i | QUIET_BIT;
        end else if ((a_inf && b_inf) || both_zero) begin
          item_d.hdr.spec_val = DEFAULT_NAN;
        end else if (a_inf || b_zero) begin
          item_d.hdr.spec_val = {a_i[31] ^ b_i[31], 8'hFF, 23'd0};
        end else if (a_zero || b_inf) begin
          item_d.hdr.spec_val = {a_i[31] ^ b_i[31], 31'd0};
        end else begin
          item_d.hdr.spec = 1'b0;
        end
      end
      OP_MAX: begin
        item_d.hdr.spec     = 1'b1;
        item_d.hdr.spec_val = (a_nan || b_nan) ? MINMAX_NAN : (a_gt_b ? a_i : b_i);
      end
      OP_MIN: begin
        item_d.hdr.spec     = 1'b1;
        item_d.hdr.spec_val = (a_nan || b_nan) ? MINMAX_NAN : (b_gt_a ? a_i : b_i);
      end
      default: begin
        item_d.hdr.spec     = 1'b1;
        item_d.hdr.spec_val = a_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hw/rtl/fsdm_addsub.sv =====
// three-stage magnitude add/subtract: align, add, normalize
module fsdm_addsub (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  fsdm_pkg::front_t item_i,
  output logic             valid_o,
  output fsdm_pkg::rnd_t   item_o
);
  import fsdm_pkg::*;

  logic [2:0] valid_q;

  // align stage
  logic [7:0]  d;
  logic [4:0]  dc;
  logic [53:0] wide;
  hdr_t        hdr1_q;
  logic        sign1_q, sub1_q;
  logic [7:0]  ex1_q;
  logic [26:0] mx1_q, my1_q;

  always_comb begin
    d    = item_i.ex - item_i.ey;
    dc   = (d > 8'd27) ? 5'd27 : d[4:0];
    wide = {item_i.my, 3'b000, 27'd0} >> dc;
  end

  // add stage
  logic [27:0] sum;
  hdr_t        hdr2_q;
  logic        sign2_q, sub2_q;
  logic [7:0]  ex2_q;
  logic [27:0] sum2_q;

  always_comb begin
    if (sub1_q) sum = {1'b0, mx1_q} - {1'b0, my1_q};
    else        sum = {1'b0, mx1_q} + {1'b0, my1_q};
  end

  // normalize stage
  logic [4:0] lz;
  rnd_t       rnd_d, rnd_q;

  always_comb begin
    lz              = lzc28(sum2_q);
    rnd_d.hdr       = hdr2_q;
    rnd_d.zero      = (sum2_q == 28'd0);
    // exact cancellation rounds to +0
    rnd_d.sign      = rnd_d.zero ? (sign2_q & ~sub2_q) : sign2_q;
    rnd_d.e         = {3'b000, ex2_q} + 11'd1 - {6'd0, lz};
    rnd_d.m         = sum2_q << lz;
    rnd_d.sticky    = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hdr1_q  <= item_i.hdr;
      sign1_q <= item_i.sign;
      sub1_q  <= item_i.eff_sub;
      ex1_q   <= item_i.ex;
      mx1_q   <= {item_i.mx, 3'b000};
      my1_q   <= {wide[53:28], wide[27] | (|wide[26:0])};
      hdr2_q  <= hdr1_q;
      sign2_q <= sign1_q;
      sub2_q  <= sub1_q;
      ex2_q   <= ex1_q;
      sum2_q  <= sum;
      rnd_q   <= rnd_d;
    end
  end

  assign valid_o = valid_q[2];
  assign item_o  = rnd_q;

endmodule

// ===== hw/rtl/fsdm_divider.sv =====
// pipelined restoring divider, one quotient bit per stage
module fsdm_divider (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  fsdm_pkg::front_t item_i,
  output logic             valid_o,
  output fsdm_pkg::rnd_t   item_o
);
  import fsdm_pkg::*;

  typedef struct packed {
    hdr_t        hdr;
    logic        sign;
    logic [10:0] e;
    logic [24:0] rem;
    logic [23:0] mb;
    logic [27:0] q;
  } div_stage_t;

  div_stage_t st_q [DIV_STEPS+1];
  logic       v_q  [DIV_STEPS+1];

  // normalize both mantissas so subnormals divide like normals
  logic [4:0]  lza, lzb;
  div_stage_t  st0_d;

  always_comb begin
    lza        = lzc28({item_i.mx, 4'hF});
    lzb        = lzc28({item_i.my, 4'hF});
    st0_d.hdr  = item_i.hdr;
    st0_d.sign = item_i.sign;
    st0_d.e    = {3'b000, item_i.ex} - {6'd0, lza} - {3'b000, item_i.ey}
                 + {6'd0, lzb} + 11'd127;
    st0_d.rem  = {1'b0, item_i.mx << lza};
    st0_d.mb   = item_i.my << lzb;
    st0_d.q    = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= st0_d;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic        ge;
    logic [24:0] nrem;
    div_stage_t  nxt;

    always_comb begin
      ge       = st_q[k].rem >= {1'b0, st_q[k].mb};
      nrem     = ge ? (st_q[k].rem - {1'b0, st_q[k].mb}) : st_q[k].rem;
      nxt      = st_q[k];
      nxt.rem  = {nrem[23:0], 1'b0};
      nxt.q    = {st_q[k].q[26:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k+1] <= nxt;
      end
    end
  end

  // quotient lies in (0.5, 2): at most one left shift
  div_stage_t last_st;
  rnd_t       rnd_d, rnd_q;
  logic       vout_q;

  always_comb begin
    last_st      = st_q[DIV_STEPS];
    rnd_d.hdr    = last_st.hdr;
    rnd_d.sign   = last_st.sign;
    rnd_d.zero   = 1'b0;
    rnd_d.sticky = (last_st.rem != 25'd0);
    if (last_st.q[27]) begin
      rnd_d.m = last_st.q;
      rnd_d.e = last_st.e;
    end else begin
      rnd_d.m = {last_st.q[26:0], 1'b0};
      rnd_d.e = last_st.e - 11'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vout_q <= 1'b0;
    end else if (en_i) begin
      vout_q <= v_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rnd_q <= rnd_d;
    end
  end

  assign valid_o = vout_q;
  assign item_o  = rnd_q;

endmodule

// ===== hw/rtl/fsdm_round.sv =====
// two-stage rounding: subnormal shift, then round-to-nearest-even and pack
module fsdm_round (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  fsdm_pkg::rnd_t item_i,
  output logic           valid_o,
  output logic [31:0]    result_o,
  output logic           last_o
);
  import fsdm_pkg::*;

  logic [1:0]  valid_q;
  logic [10:0] sh;
  logic [4:0]  shc;
  logic [55:0] wide;
  logic [7:0]  ef_d;
  logic [27:0] ms_d;
  logic        st_d, ovf_d;

  hdr_t        hdr_q;
  logic        sign_q, zero_q, ovf_q, st_q;
  logic [7:0]  ef_q;
  logic [27:0] ms_q;

  always_comb begin
    sh    = 11'd1 - item_i.e;
    shc   = (sh > 11'd28) ? 5'd28 : sh[4:0];
    wide  = {item_i.m, 28'd0} >> shc;
    ovf_d = $signed(item_i.e) > $signed(11'd254);
    if ($signed(item_i.e) > $signed(11'd0)) begin
      ef_d = item_i.e[7:0];
      ms_d = item_i.m;
      st_d = item_i.sticky;
    end else begin
      ef_d = 8'd0;
      ms_d = wide[55:28];
      st_d = item_i.sticky | (|wide[27:0]);
    end
  end

  logic [30:0] keep, packed_v;
  logic        up;
  logic [31:0] res_d, res_q;
  logic        last_q;

  always_comb begin
    keep     = {ef_q, ms_q[26:4]};
    up       = ms_q[3] & ((|ms_q[2:0]) | st_q | keep[0]);
    // a carry out of the fraction bumps the exponent, up to infinity
    packed_v = keep + {30'd0, up};
    if (hdr_q.spec)  res_d = hdr_q.spec_val;
    else if (zero_q) res_d = {sign_q, 31'd0};
    else if (ovf_q)  res_d = {sign_q, 8'hFF, 23'd0};
    else             res_d = {sign_q, packed_v};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hdr_q  <= item_i.hdr;
      sign_q <= item_i.sign;
      zero_q <= item_i.zero;
      ovf_q  <= ovf_d;
      ef_q   <= ef_d;
      ms_q   <= ms_d;
      st_q   <= st_d;
      res_q  <= res_d;
      last_q <= hdr_q.last;
    end
  end

  assign valid_o  = valid_q[1];
  assign result_o = res_q;
  assign last_o   = last_q;

endmodule

// ===== hw/rtl/fp32_sub_div_minmax_unit.sv =====
// top level of the pipelined binary32 sub/div/min/max unit
// every operation passes the same registers from input acceptance to result valid
// throughput: one item per cycle unless the output item is held, set by the 28-stage bit-per-stage divider pipe
// the whole pipe advances together; it stalls only when the output item is held
// reset clears all valid bits and sets the operation register to subtract
module fp32_sub_div_minmax_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] operand_a_i,
  input  logic [31:0] operand_b_i,
  input  logic        last_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] result_value_o,
  output logic        last_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i
);
  import fsdm_pkg::*;

  // operation register, always writable
  logic [2:0] op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_SUB;
    end else if (cfg_valid_i) begin
      op_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // global advance: every stage moves unless the output item is held
  logic en;
  assign en         = ~out_valid_o | ~out_stall_i;
  assign in_stall_o = ~en;

  // classify operands, resolve special cases, min/max and pass
  logic   front_v;
  front_t front_item;

  fsdm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .a_i     (operand_a_i),
    .b_i     (operand_b_i),
    .last_i  (last_in_i),
    .op_i    (op_q),
    .valid_o (front_v),
    .item_o  (front_item)
  );

  // both datapaths see every item; the header picks which result counts
  logic add_v, div_v;
  rnd_t add_item, div_item;

  fsdm_addsub u_addsub (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_v),
    .item_i  (front_item),
    .valid_o (add_v),
    .item_o  (add_item)
  );

  fsdm_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_v),
    .item_i  (front_item),
    .valid_o (div_v),
    .item_o  (div_item)
  );

  // delay line that lines the short subtract path up with the divider
  rnd_t dly_q [ALIGN_LAT];
  logic dv_q  [ALIGN_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ALIGN_LAT; i++) dv_q[i] <= 1'b0;
    end else if (en) begin
      dv_q[0] <= add_v;
      for (int i = 1; i < ALIGN_LAT; i++) dv_q[i] <= dv_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dly_q[0] <= add_item;
      for (int i = 1; i < ALIGN_LAT; i++) dly_q[i] <= dly_q[i-1];
    end
  end

  // merge point: both copies of an item arrive in the same cycle
  logic merge_v;
  rnd_t merge_item;

  assign merge_v    = div_v & dv_q[ALIGN_LAT-1];
  assign merge_item = div_item.hdr.is_div ? div_item : dly_q[ALIGN_LAT-1];

  // rounding; its last register is the output register
  fsdm_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (merge_v),
    .item_i   (merge_item),
    .valid_o  (out_valid_o),
    .result_o (result_value_o),
    .last_o   (last_out_o)
  );

endmodule

// ===== hw/rtl/fsdm_checker.sv =====
// port-level checks of the binary32 unit and their bind to the top level
`include "assert_macros.svh"

module fsdm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] result_value_o,
  input logic        last_out_o
);

  // a held output item keeps its value
  `FSDM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(result_value_o) && $stable(last_out_o))

  // input stalls only when a finished item is being held at the output
  `FSDM_ASSERT(a_stall_src, clk_i, rst_ni, in_stall_o |-> (out_valid_o && out_stall_i))

  // output valid only rises after the pipe advanced
  `FSDM_ASSERT(a_out_rise, clk_i, rst_ni, $rose(out_valid_o) |-> $past(!in_stall_o))

endmodule

bind fp32_sub_div_minmax_unit fsdm_checker u_fsdm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .result_value_o (result_value_o),
  .last_out_o     (last_out_o)
);
